>>> src/fir_df_pkg.sv
// Shared types and constants for the direct-form FIR filter.
// No dependencies; used by fir_filter_direct_form.
`timescale 1ns / 1ps

package fir_df_pkg;

    localparam int TAPS_DEFAULT         = 32;
    localparam int SAMPLE_WIDTH_DEFAULT = 16;
    localparam int COEF_INDEX_WIDTH     = 5;

    // Command codes carried by an input item.
    localparam logic CMD_FILTER     = 1'b0;
    localparam logic CMD_COEF_WRITE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_ROUND,
        ST_EMIT
    } t_state;

endpackage

>>> src/fir_filter_direct_form.sv
// Direct-form FIR filter: one shared multiplier and saturating accumulator under a sequencer.
// A sample item is processed in full before the next item is accepted:
// one multiply-accumulate per tap through a registered memory read, product and accumulate
// stage, then rounding and saturation.
// A coefficient-write item is taken in the idle state and gives no result.
// Reset (synchronous, active low) clears control state and marks all taps and history as zero.
`timescale 1ns / 1ps

module fir_filter_direct_form #(
    parameter int TAPS         = fir_df_pkg::TAPS_DEFAULT,
    parameter int SAMPLE_WIDTH = fir_df_pkg::SAMPLE_WIDTH_DEFAULT
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_valid,
    output logic                                     o_ready,
    input  logic                                     i_command,
    input  logic signed [SAMPLE_WIDTH-1:0]           i_sample,
    input  logic [fir_df_pkg::COEF_INDEX_WIDTH-1:0]  i_coef_index,
    input  logic signed [SAMPLE_WIDTH-1:0]           i_coef_value,
    output logic                                     o_valid,
    input  logic                                     i_ready,
    output logic signed [SAMPLE_WIDTH-1:0]           o_filtered,
    output logic                                     o_saturated
);

    localparam int HIST_LEN = TAPS - 1;
    localparam int CW       = $clog2(TAPS);
    localparam int HW       = (HIST_LEN > 1) ? $clog2(HIST_LEN) : 1;
    localparam int FRAC_W   = SAMPLE_WIDTH - 1;
    localparam int PROD_W   = 2 * SAMPLE_WIDTH;
    localparam int ACC_FULL = PROD_W + $clog2(TAPS);
    localparam int ACC_W    = (ACC_FULL > 64) ? 64 : ACC_FULL;

    fir_df_pkg::t_state r_state, n_state;

    logic signed [SAMPLE_WIDTH-1:0] coef_mem [TAPS];
    logic signed [SAMPLE_WIDTH-1:0] hist_mem [HIST_LEN];
    logic [TAPS-1:0]                r_coef_vld;
    logic [HIST_LEN-1:0]            r_hist_vld;

    logic signed [SAMPLE_WIDTH-1:0] r_x;
    logic [HW-1:0]                  r_head;
    logic [HW-1:0]                  r_pos;
    logic [CW-1:0]                  r_k;

    logic signed [SAMPLE_WIDTH-1:0] r_coef_q;
    logic signed [SAMPLE_WIDTH-1:0] r_hist_q;
    logic                           r_coef_ok;
    logic                           r_hist_ok;
    logic                           r_s1_v;
    logic                           r_s1_first;
    logic signed [PROD_W-1:0]       r_prod;
    logic                           r_s2_v;
    logic signed [ACC_W-1:0]        r_acc;

    logic                           r_out_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_filtered;
    logic                           r_saturated;

    logic                           accept;
    logic                           sample_go;
    logic                           coef_wr;
    logic                           issue;
    logic                           round_go;
    logic                           emit_go;
    logic [HW-1:0]                  head_prev;
    logic [HW-1:0]                  pos_prev;
    logic [HW-1:0]                  head_next;

    logic signed [SAMPLE_WIDTH-1:0] mul_a;
    logic signed [SAMPLE_WIDTH-1:0] mul_b;
    logic signed [ACC_W-1:0]        add_b;
    logic [ACC_W:0]                 add_sum;
    logic signed [ACC_W-1:0]        add_res;

    logic [ACC_W-PROD_W+1:0]        acc_hi;
    logic                           out_sat;
    logic signed [SAMPLE_WIDTH-1:0] out_val;

    assign o_ready     = (r_state == fir_df_pkg::ST_IDLE);
    assign accept      = i_valid && o_ready;
    assign sample_go   = accept && (i_command == fir_df_pkg::CMD_FILTER);
    assign coef_wr     = accept && (i_command == fir_df_pkg::CMD_COEF_WRITE)
                         && (32'(i_coef_index) < 32'(TAPS));
    assign issue       = (r_state == fir_df_pkg::ST_MAC);
    assign round_go    = (r_state == fir_df_pkg::ST_ROUND);
    assign emit_go     = (r_state == fir_df_pkg::ST_EMIT) && (!r_out_valid || i_ready);

    assign head_prev = (r_head == '0) ? HW'(HIST_LEN - 1) : r_head - HW'(1);
    assign pos_prev  = (r_pos == '0) ? HW'(HIST_LEN - 1) : r_pos - HW'(1);
    assign head_next = (r_head == HW'(HIST_LEN - 1)) ? '0 : r_head + HW'(1);

    // A tap whose coefficient or history slot was never written since reset reads as zero.
    assign mul_a = r_coef_ok ? r_coef_q : '0;
    assign mul_b = r_s1_first ? r_x : (r_hist_ok ? r_hist_q : '0);

    // The one adder serves the tap sums and the rounding step, saturating at its width.
    always_comb begin
        add_b   = round_go ? (ACC_W'(1) <<< (FRAC_W - 1)) : ACC_W'(r_prod);
        add_sum = {r_acc[ACC_W-1], r_acc} + {add_b[ACC_W-1], add_b};
        if (add_sum[ACC_W] != add_sum[ACC_W-1]) begin
            add_res = add_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
            add_res = add_sum[ACC_W-1:0];
        end
    end

    // Dropping FRAC_W bits floors; the output fits when every bit above it matches the sign.
    always_comb begin
        acc_hi  = r_acc[ACC_W-1:PROD_W-2];
        out_sat = !((&acc_hi) || (~|acc_hi));
        if (out_sat) begin
            out_val = r_acc[ACC_W-1] ? {1'b1, {(SAMPLE_WIDTH-1){1'b0}}}
                                     : {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
        end else begin
            out_val = r_acc[PROD_W-2:FRAC_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fir_df_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fir_df_pkg::ST_IDLE: begin
                if (sample_go) begin
                    n_state = fir_df_pkg::ST_MAC;
                end
            end
            fir_df_pkg::ST_MAC: begin
                if (r_k == CW'(TAPS - 1)) begin
                    n_state = fir_df_pkg::ST_DRAIN;
                end
            end
            fir_df_pkg::ST_DRAIN: begin
                // The last product is added on the edge that leaves this state.
                if (!r_s1_v) begin
                    n_state = fir_df_pkg::ST_ROUND;
                end
            end
            fir_df_pkg::ST_ROUND: begin
                n_state = fir_df_pkg::ST_EMIT;
            end
            fir_df_pkg::ST_EMIT: begin
                if (emit_go) begin
                    n_state = fir_df_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = fir_df_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers and valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_vld  <= '0;
            r_hist_vld  <= '0;
            r_head      <= '0;
            r_k         <= '0;
            r_s1_v      <= 1'b0;
            r_s2_v      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (coef_wr) begin
                r_coef_vld[CW'(i_coef_index)] <= 1'b1;
            end
            if (round_go) begin
                r_hist_vld[r_head] <= 1'b1;
                r_head             <= head_next;
            end
            if (sample_go) begin
                r_k <= '0;
            end else if (issue) begin
                r_k <= r_k + CW'(1);
            end
            r_s1_v <= issue;
            r_s2_v <= r_s1_v;
            if (emit_go) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Memories and datapath.
    always_ff @(posedge i_clk) begin
        if (coef_wr) begin
            coef_mem[CW'(i_coef_index)] <= i_coef_value;
        end
        if (round_go) begin
            hist_mem[r_head] <= r_x;
        end

        r_coef_q   <= coef_mem[r_k];
        r_hist_q   <= hist_mem[r_pos];
        r_coef_ok  <= r_coef_vld[r_k];
        r_hist_ok  <= r_hist_vld[r_pos];
        r_s1_first <= (r_k == '0);

        if (sample_go) begin
            r_x   <= i_sample;
            r_pos <= head_prev;
        end else if (issue && (r_k != '0)) begin
            r_pos <= pos_prev;
        end

        r_prod <= mul_a * mul_b;

        if (sample_go) begin
            r_acc <= '0;
        end else if (r_s2_v || round_go) begin
            r_acc <= add_res;
        end

        if (emit_go) begin
            r_filtered  <= out_val;
            r_saturated <= out_sat;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_filtered  = r_filtered;
    assign o_saturated = r_saturated;

endmodule
